// ----- hw/rtl/euqc_pkg.sv -----
// euqc_pkg: shared widths, fixed-point constants, the arctangent table and the
// record types passed between the front, the queue and the back of the converter.
// No dependencies.
`timescale 1ns / 1ps

package euqc_pkg;

  // internal fixed point uses 28 fraction bits
  localparam int FRAC = 28;
  localparam int XW = 38;
  localparam int ZW = 32;
  localparam int ZIW = 31;
  localparam int PW = 32;
  localparam int MW = 31;
  localparam int SQW = 58;
  localparam int SQRT_STEPS = SQW / 2;
  localparam int TAB_LEN = 24;
  localparam int QDEPTH = 2;

  localparam int HALF_PI_Q = 421657428;
  localparam int PI_Q = 843314857;
  localparam int INV_GAIN_Q = 163008219;
  localparam int ONE_Q = 268435456;
  localparam int ANG_MAX = 25736;

  // outside the cordic: front, queue, setup, root steps, pre-rotate, four tail stages
  localparam int FIXED_STAGES = SQRT_STEPS + 8;

  typedef logic signed [ZIW-1:0] zin_t;
  typedef logic signed [PW-1:0] prod_t;

  typedef struct packed {
    logic       func;
    logic [2:0] neg;
    zin_t       z_roll;
    zin_t       z_pitch;
    zin_t       z_yaw;
    prod_t      wi;
    prod_t      jk;
    prod_t      wk;
    prod_t      ij;
    prod_t      ii;
    prod_t      jj;
    prod_t      kk;
    prod_t      wj;
    prod_t      ik;
  } item_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } lane_t;

  typedef struct packed {
    logic       func;
    logic [2:0] neg;
    logic [2:0] zero;
  } ctl_t;

  typedef struct packed {
    logic [SQW-1:0] v;
    logic [SQW-1:0] res;
  } sq_t;

  // round(atan(2^-n) * 2^28)
  function automatic int atan_q(input int n);
    int r;
    case (n)
      0:  r = 210828714;
      1:  r = 124459457;
      2:  r = 65760959;
      3:  r = 33381290;
      4:  r = 16755422;
      5:  r = 8385879;
      6:  r = 4193963;
      7:  r = 2097109;
      8:  r = 1048571;
      9:  r = 524287;
      10: r = 262144;
      11: r = 131072;
      12: r = 65536;
      13: r = 32768;
      14: r = 16384;
      15: r = 8192;
      16: r = 4096;
      17: r = 2048;
      18: r = 1024;
      19: r = 512;
      20: r = 256;
      21: r = 128;
      22: r = 64;
      23: r = 32;
      default: r = 0;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/euler_quaternion_convert.sv -----
// euler_quaternion_convert: top level of the Euler angle / quaternion converter.
// Instantiates euqc_front, euqc_queue and euqc_back; depends on euqc_pkg.
`timescale 1ns / 1ps

// Usage:
//   Command channel: drive in_* and raise start; the command transfers at a
//   rising edge where start is high and busy is low. in_func picks the
//   direction: 0 turns roll/pitch/yaw (Q3.13 rad) into w/i/j/k (Q2.14),
//   1 turns a quaternion into roll/pitch/yaw.
//   Result channel: out_valid is high for exactly one cycle per command and
//   the out_* fields are valid in that cycle; out_kind_out echoes in_func and
//   the fields that do not belong to that direction read zero.
//   Path: a result passes the front register, the queue, the setup stage,
//   the 29-stage root pipeline, the pre-rotation stage, the cordic stages
//   and the product tail before out_valid marks it.
//   Throughput: one command every cycle; the pipeline is fully unrolled and
//   the queue between front and back drains each cycle, so busy stays low.
//   Results come out in command order.
//   Reset: synchronous, active low; clears all valid flags, nothing in
//   flight survives. The receiver cannot stall, so no result is ever held.
module euler_quaternion_convert #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_func,
  input  logic signed [15:0]   in_roll_in,
  input  logic signed [15:0]   in_pitch_in,
  input  logic signed [15:0]   in_yaw_in,
  input  logic signed [15:0]   in_qw_in,
  input  logic signed [15:0]   in_qi_in,
  input  logic signed [15:0]   in_qj_in,
  input  logic signed [15:0]   in_qk_in,
  output logic                 out_valid,
  output logic                 out_kind_out,
  output logic signed [15:0]   out_roll_out,
  output logic signed [15:0]   out_pitch_out,
  output logic signed [15:0]   out_yaw_out,
  output logic signed [15:0]   out_qw_out,
  output logic signed [15:0]   out_qi_out,
  output logic signed [15:0]   out_qj_out,
  output logic signed [15:0]   out_qk_out
);

  localparam int LATENCY = CORDIC_STEPS + euqc_pkg::FIXED_STAGES;

  logic            push, q_full, q_valid;
  euqc_pkg::item_t f_item, q_item;

  euqc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_func     (in_func),
    .in_roll_in  (in_roll_in),
    .in_pitch_in (in_pitch_in),
    .in_yaw_in   (in_yaw_in),
    .in_qw_in    (in_qw_in),
    .in_qi_in    (in_qi_in),
    .in_qj_in    (in_qj_in),
    .in_qk_in    (in_qk_in),
    .q_full      (q_full),
    .push        (push),
    .item        (f_item)
  );

  euqc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (f_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  euqc_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (q_valid),
    .item          (q_item),
    .out_valid     (out_valid),
    .out_kind_out  (out_kind_out),
    .out_roll_out  (out_roll_out),
    .out_pitch_out (out_pitch_out),
    .out_yaw_out   (out_yaw_out),
    .out_qw_out    (out_qw_out),
    .out_qi_out    (out_qi_out),
    .out_qj_out    (out_qj_out),
    .out_qk_out    (out_qk_out)
  );

`ifndef SYNTHESIS
  a_result_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching command");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("front stalled although the back drains every cycle");

  a_quat_zero_angles: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind_out |->
      out_roll_out == '0 && out_pitch_out == '0 && out_yaw_out == '0)
    else $error("angle fields not zero on a quaternion result");

  a_angle_zero_quat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind_out |->
      out_qw_out == '0 && out_qi_out == '0 && out_qj_out == '0 && out_qk_out == '0)
    else $error("quaternion fields not zero on an angle result");
`endif

endmodule

// ----- hw/rtl/euqc_front.sv -----
// euqc_front: takes commands, folds half angles into +-pi/2 and forms the
// quaternion products, and holds one classified item for the queue.
// Depends on euqc_pkg.
`timescale 1ns / 1ps

module euqc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_func,
  input  logic signed [15:0]   in_roll_in,
  input  logic signed [15:0]   in_pitch_in,
  input  logic signed [15:0]   in_yaw_in,
  input  logic signed [15:0]   in_qw_in,
  input  logic signed [15:0]   in_qi_in,
  input  logic signed [15:0]   in_qj_in,
  input  logic signed [15:0]   in_qk_in,
  input  logic                 q_full,
  output logic                 push,
  output euqc_pkg::item_t      item
);

  typedef struct packed {
    euqc_pkg::zin_t z;
    logic           neg;
  } fold_t;

  logic            valid_r, valid_nxt;
  logic            accept;
  euqc_pkg::item_t item_r, item_nxt;
  fold_t           f_roll, f_pitch, f_yaw;

  function automatic fold_t fold_angle(input logic signed [15:0] v);
    logic signed [euqc_pkg::ZW-1:0] z;
    fold_t f;
    z = euqc_pkg::ZW'(v) <<< 14;
    f.neg = 1'b0;
    if (z > euqc_pkg::ZW'(euqc_pkg::HALF_PI_Q)) begin
      z = z - euqc_pkg::ZW'(euqc_pkg::PI_Q);
      f.neg = 1'b1;
    end else if (z < -euqc_pkg::ZW'(euqc_pkg::HALF_PI_Q)) begin
      z = z + euqc_pkg::ZW'(euqc_pkg::PI_Q);
      f.neg = 1'b1;
    end
    f.z = euqc_pkg::ZIW'(z);
    return f;
  endfunction

  function automatic euqc_pkg::prod_t mul16(input logic signed [15:0] a,
                                           input logic signed [15:0] b);
    return euqc_pkg::PW'(a) * euqc_pkg::PW'(b);
  endfunction

  assign busy   = valid_r && q_full;
  assign accept = start && !busy;
  assign push   = valid_r && !q_full;
  assign item   = item_r;

  always_comb begin
    f_roll  = fold_angle(in_roll_in);
    f_pitch = fold_angle(in_pitch_in);
    f_yaw   = fold_angle(in_yaw_in);
    item_nxt.func    = in_func;
    // the sign flip only matters on the rotation path
    item_nxt.neg     = in_func ? 3'b000 : {f_yaw.neg, f_pitch.neg, f_roll.neg};
    item_nxt.z_roll  = f_roll.z;
    item_nxt.z_pitch = f_pitch.z;
    item_nxt.z_yaw   = f_yaw.z;
    item_nxt.wi = mul16(in_qw_in, in_qi_in);
    item_nxt.jk = mul16(in_qj_in, in_qk_in);
    item_nxt.wk = mul16(in_qw_in, in_qk_in);
    item_nxt.ij = mul16(in_qi_in, in_qj_in);
    item_nxt.ii = mul16(in_qi_in, in_qi_in);
    item_nxt.jj = mul16(in_qj_in, in_qj_in);
    item_nxt.kk = mul16(in_qk_in, in_qk_in);
    item_nxt.wj = mul16(in_qw_in, in_qj_in);
    item_nxt.ik = mul16(in_qi_in, in_qk_in);
    valid_nxt = accept ? 1'b1 : (push ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ----- hw/rtl/euqc_queue.sv -----
// euqc_queue: short first-in first-out queue of classified items between the
// front and the back.
// Depends on euqc_pkg.
`timescale 1ns / 1ps

module euqc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  euqc_pkg::item_t push_item,
  output logic            full,
  output logic            pop_valid,
  output euqc_pkg::item_t pop_item
);

  localparam int AW = $clog2(euqc_pkg::QDEPTH);
  localparam int CW = $clog2(euqc_pkg::QDEPTH + 1);

  euqc_pkg::item_t mem_r [euqc_pkg::QDEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            pop;

  assign full      = (count_r == CW'(euqc_pkg::QDEPTH));
  assign pop_valid = (count_r != '0);
  // the back never stalls, so a waiting entry leaves every cycle
  assign pop       = pop_valid;
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(euqc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(euqc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue write while full");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count lost a transfer");
`endif

endmodule

// ----- hw/rtl/euqc_back.sv -----
// euqc_back: the fully pipelined datapath: setup of the vectors, two square
// root pipelines, three cordic lanes and the product and rounding tail.
// Depends on euqc_pkg.
`timescale 1ns / 1ps

module euqc_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  euqc_pkg::item_t      item,
  output logic                 out_valid,
  output logic                 out_kind_out,
  output logic signed [15:0]   out_roll_out,
  output logic signed [15:0]   out_pitch_out,
  output logic signed [15:0]   out_yaw_out,
  output logic signed [15:0]   out_qw_out,
  output logic signed [15:0]   out_qi_out,
  output logic signed [15:0]   out_qj_out,
  output logic signed [15:0]   out_qk_out
);

  localparam int XW   = euqc_pkg::XW;
  localparam int ZW   = euqc_pkg::ZW;
  localparam int MW   = euqc_pkg::MW;
  localparam int SQW  = euqc_pkg::SQW;
  localparam int FRAC = euqc_pkg::FRAC;
  localparam int NSQ  = euqc_pkg::SQRT_STEPS;

  // square root pipeline, index 0 is the setup stage
  logic              sq_valid_r [NSQ+1];
  euqc_pkg::ctl_t    sq_ctl_r   [NSQ+1];
  euqc_pkg::lane_t   sq_lane_r  [NSQ+1][3];
  euqc_pkg::sq_t     sq_a_r     [NSQ+1];
  euqc_pkg::sq_t     sq_b_r     [NSQ+1];

  // cordic pipeline, index 0 is the pre-rotation stage
  logic              c_valid_r  [CORDIC_STEPS+1];
  euqc_pkg::ctl_t    c_ctl_r    [CORDIC_STEPS+1];
  euqc_pkg::lane_t   c_lane_r   [CORDIC_STEPS+1][3];

  // setup
  euqc_pkg::ctl_t    b0_ctl;
  euqc_pkg::lane_t   b0_lane [3];
  euqc_pkg::sq_t     b0_a, b0_b;
  logic signed [XW-1:0] r_y, r_x, y_y, y_x, s_raw, s_cl, ap, bp;

  // pre-rotation
  euqc_pkg::lane_t   p_lane [3];

  // tail
  logic                 m0_valid_r, m1_valid_r, m2_valid_r;
  logic                 m0_func_r, m1_func_r, m2_func_r;
  logic signed [MW-1:0] m0_c_r [3];
  logic signed [MW-1:0] m0_s_r [3];
  logic signed [15:0]   m0_ang_r [3];
  logic signed [15:0]   m1_ang_r [3];
  logic signed [15:0]   m2_ang_r [3];
  logic signed [MW-1:0] m1_cc_r, m1_ss_r, m1_sc_r, m1_cs_r;
  logic signed [MW-1:0] m1_cy_r, m1_sy_r;
  logic signed [MW-1:0] m2_t_r [8];
  logic signed [ZW+1:0] ang_in [3];
  logic signed [15:0]   qw_v, qi_v, qj_v, qk_v;

  logic                 out_valid_r, out_kind_r;
  logic signed [15:0]   roll_r, pitch_r, yaw_r, qw_r, qi_r, qj_r, qk_r;

  function automatic euqc_pkg::sq_t sqrt_step(input euqc_pkg::sq_t s,
                                              input logic [SQW-1:0] b);
    logic [SQW:0]  trial;
    euqc_pkg::sq_t o;
    trial = {1'b0, s.res} + {1'b0, b};
    if ({1'b0, s.v} >= trial) begin
      o.v   = s.v - trial[SQW-1:0];
      o.res = (s.res >> 1) + b;
    end else begin
      o.v   = s.v;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  function automatic logic signed [MW-1:0] mulq(input logic signed [MW-1:0] a,
                                               input logic signed [MW-1:0] b);
    logic signed [2*MW-1:0] p;
    p = (2*MW)'(a) * (2*MW)'(b);
    p = p + ((2*MW)'(1) <<< (FRAC - 1));
    return MW'(p >>> FRAC);
  endfunction

  function automatic logic signed [15:0] q14_round(input logic signed [MW:0] v);
    logic signed [MW:0] t;
    t = (v + ((MW+1)'(1) <<< 13)) >>> 14;
    if (t > (MW+1)'(32767)) begin
      t = (MW+1)'(32767);
    end else if (t < -(MW+1)'(32768)) begin
      t = -(MW+1)'(32768);
    end
    return 16'(t);
  endfunction

  function automatic logic signed [15:0] ang_round(input logic signed [ZW+1:0] v);
    logic signed [ZW+1:0] t;
    t = (v + ((ZW+2)'(1) <<< 14)) >>> 15;
    if (t > (ZW+2)'(euqc_pkg::ANG_MAX)) begin
      t = (ZW+2)'(euqc_pkg::ANG_MAX);
    end else if (t < -(ZW+2)'(euqc_pkg::ANG_MAX)) begin
      t = -(ZW+2)'(euqc_pkg::ANG_MAX);
    end
    return 16'(t);
  endfunction

  // ---------------- setup stage ----------------
  always_comb begin
    r_y = (XW'(item.wi) + XW'(item.jk)) <<< 1;
    r_x = XW'(euqc_pkg::ONE_Q) - ((XW'(item.ii) + XW'(item.jj)) <<< 1);
    y_y = (XW'(item.wk) + XW'(item.ij)) <<< 1;
    y_x = XW'(euqc_pkg::ONE_Q) - ((XW'(item.jj) + XW'(item.kk)) <<< 1);
    s_raw = (XW'(item.wj) - XW'(item.ik)) <<< 1;
    // keep 1 +- s non-negative for the roots
    if (s_raw > XW'(euqc_pkg::ONE_Q)) begin
      s_cl = XW'(euqc_pkg::ONE_Q);
    end else if (s_raw < -XW'(euqc_pkg::ONE_Q)) begin
      s_cl = -XW'(euqc_pkg::ONE_Q);
    end else begin
      s_cl = s_raw;
    end
    ap = XW'(euqc_pkg::ONE_Q) + s_cl;
    bp = XW'(euqc_pkg::ONE_Q) - s_cl;
    b0_a.v   = {ap[SQW-FRAC-1:0], {FRAC{1'b0}}};
    b0_a.res = '0;
    b0_b.v   = {bp[SQW-FRAC-1:0], {FRAC{1'b0}}};
    b0_b.res = '0;
    b0_ctl.func = item.func;
    b0_ctl.neg  = item.neg;
    if (item.func) begin
      b0_lane[0] = '{x: r_x, y: r_y, z: '0};
      b0_lane[1] = '{x: '0, y: '0, z: '0};
      b0_lane[2] = '{x: y_x, y: y_y, z: '0};
      b0_ctl.zero = {(y_x == '0) && (y_y == '0), 1'b0, (r_x == '0) && (r_y == '0)};
    end else begin
      b0_lane[0] = '{x: XW'(euqc_pkg::INV_GAIN_Q), y: '0, z: ZW'(item.z_roll)};
      b0_lane[1] = '{x: XW'(euqc_pkg::INV_GAIN_Q), y: '0, z: ZW'(item.z_pitch)};
      b0_lane[2] = '{x: XW'(euqc_pkg::INV_GAIN_Q), y: '0, z: ZW'(item.z_yaw)};
      b0_ctl.zero = 3'b000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r[0] <= 1'b0;
    end else begin
      sq_valid_r[0] <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    sq_ctl_r[0] <= b0_ctl;
    sq_a_r[0]   <= b0_a;
    sq_b_r[0]   <= b0_b;
    for (int l = 0; l < 3; l++) begin
      sq_lane_r[0][l] <= b0_lane[l];
    end
  end

  // ---------------- square roots, one result bit per stage ----------------
  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * i);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_valid_r[i+1] <= 1'b0;
      end else begin
        sq_valid_r[i+1] <= sq_valid_r[i];
      end
    end

    always_ff @(posedge clk) begin
      sq_ctl_r[i+1] <= sq_ctl_r[i];
      sq_a_r[i+1]   <= sqrt_step(sq_a_r[i], BIT);
      sq_b_r[i+1]   <= sqrt_step(sq_b_r[i], BIT);
      for (int l = 0; l < 3; l++) begin
        sq_lane_r[i+1][l] <= sq_lane_r[i][l];
      end
    end
  end

  // ---------------- pre-rotation into the right half plane ----------------
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      p_lane[l] = sq_lane_r[NSQ][l];
    end
    if (sq_ctl_r[NSQ].func) begin
      p_lane[1].x = XW'(sq_b_r[NSQ].res);
      p_lane[1].y = XW'(sq_a_r[NSQ].res);
      p_lane[1].z = '0;
      for (int l = 0; l < 3; l += 2) begin
        if (sq_lane_r[NSQ][l].x < 0) begin
          if (sq_lane_r[NSQ][l].y >= 0) begin
            p_lane[l].x = sq_lane_r[NSQ][l].y;
            p_lane[l].y = -sq_lane_r[NSQ][l].x;
            p_lane[l].z = ZW'(euqc_pkg::HALF_PI_Q);
          end else begin
            p_lane[l].x = -sq_lane_r[NSQ][l].y;
            p_lane[l].y = sq_lane_r[NSQ][l].x;
            p_lane[l].z = -ZW'(euqc_pkg::HALF_PI_Q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r[0] <= 1'b0;
    end else begin
      c_valid_r[0] <= sq_valid_r[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    c_ctl_r[0] <= sq_ctl_r[NSQ];
    for (int l = 0; l < 3; l++) begin
      c_lane_r[0][l] <= p_lane[l];
    end
  end

  // ---------------- cordic stages, rotation or vectoring per item ----------------
  for (genvar n = 0; n < CORDIC_STEPS; n++) begin : g_cordic
    localparam logic signed [ZW-1:0] ATAN = ZW'(euqc_pkg::atan_q(n));
    euqc_pkg::lane_t nl [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        logic                 d;
        logic signed [XW-1:0] xs, ys;
        xs = c_lane_r[n][l].x >>> n;
        ys = c_lane_r[n][l].y >>> n;
        // vectoring drives y to zero, rotation drives z to zero
        d = c_ctl_r[n].func ? (c_lane_r[n][l].y < 0) : (c_lane_r[n][l].z >= 0);
        if (d) begin
          nl[l].x = c_lane_r[n][l].x - ys;
          nl[l].y = c_lane_r[n][l].y + xs;
          nl[l].z = c_lane_r[n][l].z - ATAN;
        end else begin
          nl[l].x = c_lane_r[n][l].x + ys;
          nl[l].y = c_lane_r[n][l].y - xs;
          nl[l].z = c_lane_r[n][l].z + ATAN;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_valid_r[n+1] <= 1'b0;
      end else begin
        c_valid_r[n+1] <= c_valid_r[n];
      end
    end

    always_ff @(posedge clk) begin
      c_ctl_r[n+1] <= c_ctl_r[n];
      for (int l = 0; l < 3; l++) begin
        c_lane_r[n+1][l] <= nl[l];
      end
    end
  end

  // ---------------- tail: signs, angles, products, rounding ----------------
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (c_ctl_r[CORDIC_STEPS].zero[l]) begin
        ang_in[l] = '0;
      end else if (l == 1) begin
        ang_in[l] = ((ZW+2)'(c_lane_r[CORDIC_STEPS][l].z) <<< 1)
                    - (ZW+2)'(euqc_pkg::HALF_PI_Q);
      end else begin
        ang_in[l] = (ZW+2)'(c_lane_r[CORDIC_STEPS][l].z);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_valid_r  <= 1'b0;
      m1_valid_r  <= 1'b0;
      m2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      m0_valid_r  <= c_valid_r[CORDIC_STEPS];
      m1_valid_r  <= m0_valid_r;
      m2_valid_r  <= m1_valid_r;
      out_valid_r <= m2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    m0_func_r <= c_ctl_r[CORDIC_STEPS].func;
    for (int l = 0; l < 3; l++) begin
      m0_c_r[l] <= c_ctl_r[CORDIC_STEPS].neg[l] ? MW'(-c_lane_r[CORDIC_STEPS][l].x)
                                                : MW'(c_lane_r[CORDIC_STEPS][l].x);
      m0_s_r[l] <= c_ctl_r[CORDIC_STEPS].neg[l] ? MW'(-c_lane_r[CORDIC_STEPS][l].y)
                                                : MW'(c_lane_r[CORDIC_STEPS][l].y);
      m0_ang_r[l] <= ang_round(ang_in[l]);
    end
  end

  always_ff @(posedge clk) begin
    m1_func_r <= m0_func_r;
    m1_cc_r   <= mulq(m0_c_r[0], m0_c_r[1]);
    m1_ss_r   <= mulq(m0_s_r[0], m0_s_r[1]);
    m1_sc_r   <= mulq(m0_s_r[0], m0_c_r[1]);
    m1_cs_r   <= mulq(m0_c_r[0], m0_s_r[1]);
    m1_cy_r   <= m0_c_r[2];
    m1_sy_r   <= m0_s_r[2];
    m1_ang_r  <= m0_ang_r;
  end

  always_ff @(posedge clk) begin
    m2_func_r <= m1_func_r;
    m2_t_r[0] <= mulq(m1_cc_r, m1_cy_r);
    m2_t_r[1] <= mulq(m1_ss_r, m1_sy_r);
    m2_t_r[2] <= mulq(m1_sc_r, m1_cy_r);
    m2_t_r[3] <= mulq(m1_cs_r, m1_sy_r);
    m2_t_r[4] <= mulq(m1_cs_r, m1_cy_r);
    m2_t_r[5] <= mulq(m1_sc_r, m1_sy_r);
    m2_t_r[6] <= mulq(m1_cc_r, m1_sy_r);
    m2_t_r[7] <= mulq(m1_ss_r, m1_cy_r);
    m2_ang_r  <= m1_ang_r;
  end

  always_comb begin
    qw_v = q14_round((MW+1)'(m2_t_r[0]) + (MW+1)'(m2_t_r[1]));
    qi_v = q14_round((MW+1)'(m2_t_r[2]) - (MW+1)'(m2_t_r[3]));
    qj_v = q14_round((MW+1)'(m2_t_r[4]) + (MW+1)'(m2_t_r[5]));
    qk_v = q14_round((MW+1)'(m2_t_r[6]) - (MW+1)'(m2_t_r[7]));
  end

  // fields not meant for the chosen conversion read zero
  always_ff @(posedge clk) begin
    out_kind_r <= m2_func_r;
    roll_r     <= m2_func_r ? m2_ang_r[0] : '0;
    pitch_r    <= m2_func_r ? m2_ang_r[1] : '0;
    yaw_r      <= m2_func_r ? m2_ang_r[2] : '0;
    qw_r       <= m2_func_r ? '0 : qw_v;
    qi_r       <= m2_func_r ? '0 : qi_v;
    qj_r       <= m2_func_r ? '0 : qj_v;
    qk_r       <= m2_func_r ? '0 : qk_v;
  end

  assign out_valid     = out_valid_r;
  assign out_kind_out  = out_kind_r;
  assign out_roll_out  = roll_r;
  assign out_pitch_out = pitch_r;
  assign out_yaw_out   = yaw_r;
  assign out_qw_out    = qw_r;
  assign out_qi_out    = qi_r;
  assign out_qj_out    = qj_r;
  assign out_qk_out    = qk_r;

`ifndef SYNTHESIS
  a_zero_vec_only_vectoring: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r[0] && (c_ctl_r[0].zero != 3'b000) |-> c_ctl_r[0].func)
    else $error("zero vector flag on a rotation item");

  a_pitch_root_pos: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r[0] && c_ctl_r[0].func |-> c_lane_r[0][1].x >= 0 && c_lane_r[0][1].y >= 0)
    else $error("pitch roots not in the first quadrant");

  a_neg_only_rotation: assert property (@(posedge clk) disable iff (!rst_n)
    sq_valid_r[0] && sq_ctl_r[0].func |-> sq_ctl_r[0].neg == 3'b000)
    else $error("fold flag set on a vectoring item");
`endif

endmodule

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for euler_quaternion_convert, both directions.
// A predictor in fixed point computes each conversion; a checker compares results.
// Depends on euqc_pkg and the euler_quaternion_convert rtl.
`timescale 1ns / 1ps

module tb_top;

  localparam int STEPS = 16;
  localparam int LATENCY = STEPS + 36;
  localparam longint CYCLE_LIMIT = 200000;

  typedef enum logic {FN_E2Q = 1'b0, FN_Q2E = 1'b1} fn_e;

  typedef struct {
    logic kind;
    logic signed [15:0] roll, pitch, yaw, qw, qi, qj, qk;
  } conv_t;

  logic clk = 0, rst_n = 0, start = 0, in_func = 0;
  logic signed [15:0] in_roll_in = 0, in_pitch_in = 0, in_yaw_in = 0;
  logic signed [15:0] in_qw_in = 0, in_qi_in = 0, in_qj_in = 0, in_qk_in = 0;
  logic busy, out_valid, out_kind_out;
  logic signed [15:0] out_roll_out, out_pitch_out, out_yaw_out;
  logic signed [15:0] out_qw_out, out_qi_out, out_qj_out, out_qk_out;

  conv_t pending_q[$];
  int errors = 0, n_sent = 0, n_e2q = 0, n_q2e = 0, n_checked = 0;
  longint cycles = 0;

  euler_quaternion_convert #(.CORDIC_STEPS(STEPS)) dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 27)) >>> 28;
  endfunction

  function automatic void sin_cos(longint z, output longint c, output longint s);
    longint x, y, nx;
    bit flip;
    x = euqc_pkg::INV_GAIN_Q; y = 0; flip = 0;
    if (z > euqc_pkg::HALF_PI_Q) begin z -= euqc_pkg::PI_Q; flip = 1; end
    else if (z < -euqc_pkg::HALF_PI_Q) begin z += euqc_pkg::PI_Q; flip = 1; end
    for (int n = 0; n < STEPS; n++) begin
      if (z >= 0) begin
        nx = x - (y >>> n); y = y + (x >>> n); z -= euqc_pkg::atan_q(n);
      end else begin
        nx = x + (y >>> n); y = y - (x >>> n); z += euqc_pkg::atan_q(n);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint arctan2(longint y, longint x);
    longint z, t;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin x = y; y = -t; z = euqc_pkg::HALF_PI_Q; end
      else begin x = -y; y = t; z = -euqc_pkg::HALF_PI_Q; end
    end
    for (int n = 0; n < STEPS; n++) begin
      if (y >= 0) begin
        t = x + (y >>> n); y = y - (x >>> n); z += euqc_pkg::atan_q(n);
      end else begin
        t = x - (y >>> n); y = y + (x >>> n); z -= euqc_pkg::atan_q(n);
      end
      x = t;
    end
    return z;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin v -= r + b; r = (r >> 1) + b; end
      else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic logic signed [15:0] to_q14(longint v);
    return 16'(clip((v + (64'sd1 <<< 13)) >>> 14, -32768, 32767));
  endfunction

  function automatic logic signed [15:0] to_angle(longint z);
    return 16'(clip((z + (64'sd1 <<< 14)) >>> 15, -euqc_pkg::ANG_MAX, euqc_pkg::ANG_MAX));
  endfunction

  function automatic conv_t convert(logic fn, logic signed [15:0] r, p, yw,
                                    logic signed [15:0] w, i, j, k);
    conv_t o;
    longint cr, sr, cp, sp, cy, sy, s, ra, rb;
    o = '{kind: fn, default: '0};
    if (fn == FN_E2Q) begin
      sin_cos(longint'(r) * 16384, cr, sr);
      sin_cos(longint'(p) * 16384, cp, sp);
      sin_cos(longint'(yw) * 16384, cy, sy);
      o.qw = to_q14(qmul(qmul(cr, cp), cy) + qmul(qmul(sr, sp), sy));
      o.qi = to_q14(qmul(qmul(sr, cp), cy) - qmul(qmul(cr, sp), sy));
      o.qj = to_q14(qmul(qmul(cr, sp), cy) + qmul(qmul(sr, cp), sy));
      o.qk = to_q14(qmul(qmul(cr, cp), sy) - qmul(qmul(sr, sp), cy));
    end else begin
      o.roll = to_angle(arctan2(2 * (longint'(w) * i + longint'(j) * k),
                                euqc_pkg::ONE_Q - 2 * (longint'(i) * i + longint'(j) * j)));
      o.yaw = to_angle(arctan2(2 * (longint'(w) * k + longint'(i) * j),
                               euqc_pkg::ONE_Q - 2 * (longint'(j) * j + longint'(k) * k)));
      s = clip(2 * (longint'(w) * j - longint'(i) * k), -euqc_pkg::ONE_Q, euqc_pkg::ONE_Q);
      ra = root_floor(longint'(euqc_pkg::ONE_Q + s) << 28);
      rb = root_floor(longint'(euqc_pkg::ONE_Q - s) << 28);
      o.pitch = to_angle(-euqc_pkg::HALF_PI_Q + 2 * arctan2(ra, rb));
    end
    return o;
  endfunction

  // checker: outputs sampled at the rising edge
  always @(posedge clk) begin
    conv_t e;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing pending");
        errors++;
      end else begin
        e = pending_q.pop_front();
        n_checked++;
        if (out_kind_out !== e.kind) begin
          $error("kind_out exp %0d got %0d", e.kind, out_kind_out); errors++; end
        if (out_roll_out !== e.roll) begin
          $error("roll_out exp %0d got %0d", e.roll, out_roll_out); errors++; end
        if (out_pitch_out !== e.pitch) begin
          $error("pitch_out exp %0d got %0d", e.pitch, out_pitch_out); errors++; end
        if (out_yaw_out !== e.yaw) begin
          $error("yaw_out exp %0d got %0d", e.yaw, out_yaw_out); errors++; end
        if (out_qw_out !== e.qw) begin
          $error("qw_out exp %0d got %0d", e.qw, out_qw_out); errors++; end
        if (out_qi_out !== e.qi) begin
          $error("qi_out exp %0d got %0d", e.qi, out_qi_out); errors++; end
        if (out_qj_out !== e.qj) begin
          $error("qj_out exp %0d got %0d", e.qj, out_qj_out); errors++; end
        if (out_qk_out !== e.qk) begin
          $error("qk_out exp %0d got %0d", e.qk, out_qk_out); errors++; end
      end
    end
  end

  int burst_left = 0;

  // drive one command at the falling edge, hold start until the transfer
  task automatic send_cmd(logic fn, logic signed [15:0] r, p, yw,
                          logic signed [15:0] w, i, j, k);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      // a burst keeps start high; it drops only for a gap or in wait_drained
      if (gap > 0) begin
        start <= 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start <= 1; in_func <= fn;
    in_roll_in <= r; in_pitch_in <= p; in_yaw_in <= yw;
    in_qw_in <= w; in_qi_in <= i; in_qj_in <= j; in_qk_in <= k;
    do @(posedge clk); while (busy);
    pending_q.push_back(convert(fn, r, p, yw, w, i, j, k));
    n_sent++;
    if (fn == FN_E2Q) n_e2q++; else n_q2e++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 0;
    burst_left = 0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_angle();
    return 16'($signed($urandom_range(0, 2 * euqc_pkg::ANG_MAX)) - euqc_pkg::ANG_MAX);
  endfunction

  function automatic logic signed [15:0] rand_q();
    return 16'($urandom);
  endfunction

  task automatic test_euler_directed();
    logic signed [15:0] corner[7] = '{0, euqc_pkg::ANG_MAX, -euqc_pkg::ANG_MAX,
                                      12868, -12868, 1, -1};
    foreach (corner[a])
      send_cmd(FN_E2Q, corner[a], corner[(a + 3) % 7], corner[(a + 5) % 7],
               16'h7fff, 16'h8000, 16'hffff, 0);
    send_cmd(FN_E2Q, euqc_pkg::ANG_MAX, euqc_pkg::ANG_MAX, euqc_pkg::ANG_MAX, 0, 0, 0, 0);
    send_cmd(FN_E2Q, -euqc_pkg::ANG_MAX, -euqc_pkg::ANG_MAX, -euqc_pkg::ANG_MAX,
             0, 0, 0, 0);
  endtask

  task automatic test_quat_directed();
    send_cmd(FN_Q2E, 0, 0, 0, 16384, 0, 0, 0);
    send_cmd(FN_Q2E, 0, 0, 0, 0, 0, 0, 0);                  // all-zero quaternion
    send_cmd(FN_Q2E, 0, 0, 0, 11585, 0, 11585, 0);          // pitch +pi/2
    send_cmd(FN_Q2E, 0, 0, 0, 11585, 0, -11585, 0);         // pitch -pi/2
    send_cmd(FN_Q2E, 0, 0, 0, 32767, 0, 32767, 0);          // pitch clamp high
    send_cmd(FN_Q2E, 0, 0, 0, -32768, 0, 32767, 0);         // pitch clamp low
    send_cmd(FN_Q2E, 0, 0, 0, 0, 16384, 0, 0);              // roll at pi
    send_cmd(FN_Q2E, 0, 0, 0, 0, 0, 0, 16384);              // yaw at pi
    send_cmd(FN_Q2E, 0, 0, 0, -32768, -32768, -32768, -32768);
    send_cmd(FN_Q2E, 0, 0, 0, 32767, 32767, 32767, 32767);
    send_cmd(FN_Q2E, 25736, -25736, 1, 0, -1, 1, -16384);
  endtask

  // both directions; quats mostly unit-ish from angles, plus full-range noise
  task automatic test_random(int count);
    conv_t q;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 1) == 0) begin
        send_cmd(FN_E2Q, rand_angle(), rand_angle(), rand_angle(),
                 rand_q(), rand_q(), rand_q(), rand_q());
      end else if ($urandom_range(0, 3) != 0) begin
        q = convert(FN_E2Q, rand_angle(), rand_angle(), rand_angle(), 0, 0, 0, 0);
        send_cmd(FN_Q2E, rand_angle(), rand_angle(), rand_angle(), q.qw, q.qi, q.qj, q.qk);
      end else begin
        send_cmd(FN_Q2E, rand_angle(), rand_angle(), rand_angle(),
                 rand_q(), rand_q(), rand_q(), rand_q());
      end
      if (n == count / 2) wait_drained();
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    test_euler_directed();
    test_quat_directed();
    wait_drained();
    test_random(400);
    wait_drained();
    repeat (LATENCY + 10) @(negedge clk);
    $display("covered %0d commands: %0d euler-to-quat, %0d quat-to-euler, %0d checked",
             n_sent, n_e2q, n_q2e, n_checked);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
